[rtl/nirt_pkg.sv]
`default_nettype none
package nirt_pkg;

  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 13;
  localparam int CarrierW = 8;
  localparam int CyclesW  = 10;
  localparam int UsW      = 13;
  localparam int AddrW    = 16;
  localparam int CmdW     = 8;

  localparam logic [CfgIdxW-1:0] CFG_CARRIER_HIGH = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_CARRIER_LOW  = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_BURST        = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_HEADER       = 4'd3;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_SPACE = 4'd4;
  localparam logic [CfgIdxW-1:0] CFG_ONE_SPACE    = 4'd5;
  localparam logic [CfgIdxW-1:0] CFG_ZERO_SPACE   = 4'd6;
  localparam logic [CfgIdxW-1:0] CFG_LSB_FIRST    = 4'd7;

  localparam logic [CarrierW-1:0] RST_CARRIER_HIGH = 8'd8;
  localparam logic [CarrierW-1:0] RST_CARRIER_LOW  = 8'd18;
  localparam logic [CyclesW-1:0]  RST_BURST        = 10'd22;
  localparam logic [CyclesW-1:0]  RST_HEADER       = 10'd346;
  localparam logic [UsW-1:0]      RST_HEADER_SPACE = 13'd4500;
  localparam logic [UsW-1:0]      RST_ONE_SPACE    = 13'd1678;
  localparam logic [UsW-1:0]      RST_ZERO_SPACE   = 13'd548;

  typedef struct packed {
    logic [CarrierW-1:0] carrier_high_us;
    logic [CarrierW-1:0] carrier_low_us;
    logic [CyclesW-1:0]  burst_cycles;
    logic [CyclesW-1:0]  header_cycles;
    logic [UsW-1:0]      header_space_us;
    logic [UsW-1:0]      one_space_us;
    logic [UsW-1:0]      zero_space_us;
    logic                lsb_first;
  } cfg_t;

  typedef struct packed {
    logic led_level;
    logic busy_res;
    logic frame_done;
    logic start_ignored;
  } result_t;

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = b[i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/nirt_cfg_regs.sv]
`default_nettype none
module nirt_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [nirt_pkg::CfgIdxW-1:0]  wr_index,
  input  wire logic [nirt_pkg::CfgDataW-1:0] wr_data,
  output nirt_pkg::cfg_t                     cfg
);
  import nirt_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.carrier_high_us <= RST_CARRIER_HIGH;
      cfg_r.carrier_low_us  <= RST_CARRIER_LOW;
      cfg_r.burst_cycles    <= RST_BURST;
      cfg_r.header_cycles   <= RST_HEADER;
      cfg_r.header_space_us <= RST_HEADER_SPACE;
      cfg_r.one_space_us    <= RST_ONE_SPACE;
      cfg_r.zero_space_us   <= RST_ZERO_SPACE;
      cfg_r.lsb_first       <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_CARRIER_HIGH: cfg_r.carrier_high_us <= wr_data[CarrierW-1:0];
        CFG_CARRIER_LOW:  cfg_r.carrier_low_us  <= wr_data[CarrierW-1:0];
        CFG_BURST:        cfg_r.burst_cycles    <= wr_data[CyclesW-1:0];
        CFG_HEADER:       cfg_r.header_cycles   <= wr_data[CyclesW-1:0];
        CFG_HEADER_SPACE: cfg_r.header_space_us <= wr_data[UsW-1:0];
        CFG_ONE_SPACE:    cfg_r.one_space_us    <= wr_data[UsW-1:0];
        CFG_ZERO_SPACE:   cfg_r.zero_space_us   <= wr_data[UsW-1:0];
        CFG_LSB_FIRST:    cfg_r.lsb_first       <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[rtl/nirt_engine.sv]
`default_nettype none
module nirt_engine (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic                        req_type,
  input  wire logic [nirt_pkg::AddrW-1:0]  address,
  input  wire logic [nirt_pkg::CmdW-1:0]   command,
  input  wire logic                        extended,
  input  wire nirt_pkg::cfg_t              cfg,
  output nirt_pkg::result_t                res
);
  import nirt_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HDR_MARK, PH_HDR_SPACE, PH_BIT_MARK, PH_BIT_SPACE, PH_TRAIL_MARK
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [CyclesW-1:0] ccl_r, ccl_nxt;
  logic               cih_r, cih_nxt;
  logic [UsW-1:0]     mus_r, mus_nxt;
  logic [4:0]         bpos_r, bpos_nxt;
  logic [31:0]        frame_r, frame_nxt;
  logic [UsW-1:0]     high_us, low_us;
  logic [7:0]         byte1;
  logic               mark_end, space_end;
  logic               cur_bit;

  assign high_us = {{(UsW-CarrierW){1'b0}}, cfg.carrier_high_us};
  assign low_us  = {{(UsW-CarrierW){1'b0}}, cfg.carrier_low_us};
  assign byte1   = extended ? address[15:8] : ~address[7:0];

  always_comb begin
    phase_nxt = phase_r;
    ccl_nxt   = ccl_r;
    cih_nxt   = cih_r;
    mus_nxt   = mus_r;
    bpos_nxt  = bpos_r;
    frame_nxt = frame_r;
    res       = '0;
    mark_end  = 1'b0;
    space_end = 1'b0;
    cur_bit   = 1'b0;

    if (req_type) begin
      if (phase_r != PH_IDLE) begin
        res.start_ignored = 1'b1;
      end else begin
        if (cfg.lsb_first) begin
          frame_nxt = {rev8(address[7:0]), rev8(byte1), rev8(command), rev8(~command)};
        end else begin
          frame_nxt = {address[7:0], byte1, command, ~command};
        end
        bpos_nxt  = '0;
        phase_nxt = PH_HDR_MARK;
        ccl_nxt   = cfg.header_cycles;
        cih_nxt   = 1'b1;
        mus_nxt   = high_us;
      end
    end

    // one microsecond of the current mark or space
    if (phase_nxt == PH_HDR_MARK || phase_nxt == PH_BIT_MARK ||
        phase_nxt == PH_TRAIL_MARK) begin
      res.led_level = cih_nxt;
      if (mus_nxt > UsW'(1)) begin
        mus_nxt = mus_nxt - UsW'(1);
      end else if (cih_nxt) begin
        cih_nxt = 1'b0;
        mus_nxt = low_us;
      end else if (ccl_nxt <= CyclesW'(1)) begin
        ccl_nxt  = '0;
        mus_nxt  = '0;
        mark_end = 1'b1;
      end else begin
        ccl_nxt = ccl_nxt - CyclesW'(1);
        cih_nxt = 1'b1;
        mus_nxt = high_us;
      end
    end else if (phase_nxt == PH_HDR_SPACE || phase_nxt == PH_BIT_SPACE) begin
      if (mus_nxt > UsW'(1)) begin
        mus_nxt = mus_nxt - UsW'(1);
      end else begin
        mus_nxt   = '0;
        space_end = 1'b1;
      end
    end

    cur_bit = frame_nxt[5'd31 - bpos_nxt];

    case (phase_nxt)
      PH_IDLE: ;
      PH_HDR_MARK: begin
        res.busy_res = 1'b1;
        if (mark_end) begin
          phase_nxt = PH_HDR_SPACE;
          mus_nxt   = cfg.header_space_us;
        end
      end
      PH_HDR_SPACE: begin
        res.busy_res = 1'b1;
        if (space_end) begin
          bpos_nxt  = '0;
          phase_nxt = PH_BIT_MARK;
          ccl_nxt   = cfg.burst_cycles;
          cih_nxt   = 1'b1;
          mus_nxt   = high_us;
        end
      end
      PH_BIT_MARK: begin
        res.busy_res = 1'b1;
        if (mark_end) begin
          phase_nxt = PH_BIT_SPACE;
          mus_nxt   = cur_bit ? cfg.one_space_us : cfg.zero_space_us;
        end
      end
      PH_BIT_SPACE: begin
        res.busy_res = 1'b1;
        if (space_end) begin
          if (bpos_nxt == 5'd31) begin
            phase_nxt = PH_TRAIL_MARK;
          end else begin
            bpos_nxt  = bpos_nxt + 5'd1;
            phase_nxt = PH_BIT_MARK;
          end
          ccl_nxt = cfg.burst_cycles;
          cih_nxt = 1'b1;
          mus_nxt = high_us;
        end
      end
      PH_TRAIL_MARK: begin
        res.busy_res = 1'b1;
        if (mark_end) begin
          res.frame_done = 1'b1;
          phase_nxt      = PH_IDLE;
          cih_nxt        = 1'b0;
          bpos_nxt       = '0;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      ccl_r   <= '0;
      cih_r   <= 1'b0;
      mus_r   <= '0;
      bpos_r  <= '0;
      frame_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      ccl_r   <= ccl_nxt;
      cih_r   <= cih_nxt;
      mus_r   <= mus_nxt;
      bpos_r  <= bpos_nxt;
      frame_r <= frame_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/nec_ir_frame_transmitter.sv]
// nec infrared frame transmitter, one request per microsecond tick
// input channel: in_valid/in_ready with in_req_type (0 tick, 1 start and
//   tick), in_address, in_command, in_extended
// result channel: out_valid/out_ready, one result per request with
//   out_led_level, out_busy_res, out_frame_done, out_start_ignored
// config channel: cfg_valid/cfg_ready (always ready), cfg_index selects a
//   timing register, cfg_data is the value; unknown indexes are dropped
// output: the result of a request is registered and sits in the output
//   register from the cycle after the request is accepted
// throughput: one request per cycle unless stalled; the frame state advances
//   in one pass of logic between the state registers and the output register
// a stalled receiver holds the output register; a new request is taken in
//   the same cycle the waiting result leaves, otherwise in_ready drops
// reset: idle, no frame in flight, output empty, registers at defaults
`default_nettype none
module nec_ir_frame_transmitter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic                          in_req_type,
  input  wire logic [nirt_pkg::AddrW-1:0]    in_address,
  input  wire logic [nirt_pkg::CmdW-1:0]     in_command,
  input  wire logic                          in_extended,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic                          out_led_level,
  output      logic                          out_busy_res,
  output      logic                          out_frame_done,
  output      logic                          out_start_ignored,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [nirt_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [nirt_pkg::CfgDataW-1:0] cfg_data
);
  import nirt_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t res_r;
  logic    out_valid_r;
  logic    in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  nirt_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  nirt_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_fire),
    .req_type (in_req_type),
    .address  (in_address),
    .command  (in_command),
    .extended (in_extended),
    .cfg      (cfg),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_led_level     = res_r.led_level;
  assign out_busy_res      = res_r.busy_res;
  assign out_frame_done    = res_r.frame_done;
  assign out_start_ignored = res_r.start_ignored;

endmodule
`default_nettype wire
